### design/sstr_pkg.sv
// Shared constants, register indexes and types for the substring search block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sstr_pkg;

   localparam int MAX_PATTERN_DEFAULT    = 16;
   localparam int POSITION_WIDTH_DEFAULT = 16;

   localparam int BYTE_WIDTH      = 8;
   localparam int REG_BYTES       = 16;
   localparam int LEN_WIDTH       = 5;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int MATCH_POS_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 2'd2;

   // Control that every window cell sees in the same cycle.
   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctl_type;

endpackage

### design/sstr_cfg.sv
// Pattern configuration registers and the per-cell pattern alignment.
// Depends on sstr_pkg.
`timescale 1ns / 1ps

module sstr_cfg import sstr_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]              csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]               csr_write_data,
   output logic [LEN_WIDTH-1:0]                    eff_len,
   output logic [MAX_PATTERN-1:0][BYTE_WIDTH-1:0]  pat_aligned,
   output logic [MAX_PATTERN-1:0]                  pat_active
);

   localparam int LIMIT = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
   localparam logic [LEN_WIDTH-1:0] LIMIT_LEN = LEN_WIDTH'(LIMIT);

   logic [CSR_DATA_WIDTH-1:0] pattern_low_ff, pattern_low_in;
   logic [CSR_DATA_WIDTH-1:0] pattern_high_ff, pattern_high_in;
   logic [LEN_WIDTH-1:0]      pattern_length_ff, pattern_length_in;

   logic [LEN_WIDTH-1:0]                   eff_len_ff, eff_len_in;
   logic [MAX_PATTERN-1:0][BYTE_WIDTH-1:0] aligned_ff, aligned_in;
   logic [MAX_PATTERN-1:0]                 active_ff, active_in;

   logic [REG_BYTES-1:0][BYTE_WIDTH-1:0]   pat_bytes;
   logic [LEN_WIDTH-1:0]                   lim;
   logic [LEN_WIDTH-1:0]                   src_idx;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_PATTERN_LOW:    pattern_low_in    = csr_write_data;
            REG_PATTERN_HIGH:   pattern_high_in   = csr_write_data;
            REG_PATTERN_LENGTH: pattern_length_in = csr_write_data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The alignment is derived from the next register values, so it is ready
   // for a word accepted right after a write.
   always_comb begin
      pat_bytes = {pattern_high_in, pattern_low_in};
      lim = (pattern_length_in > LIMIT_LEN) ? LIMIT_LEN : pattern_length_in;
      // A zero byte inside the pattern ends it, as in a C string.
      eff_len_in = lim;
      for (int k = REG_BYTES - 1; k >= 0; k--) begin
         if ((LEN_WIDTH'(k) < lim) && (pat_bytes[k] == '0)) begin
            eff_len_in = LEN_WIDTH'(k);
         end
      end
   end

   // Cell j holds the j-th newest byte, which must equal pattern byte len-1-j.
   always_comb begin
      aligned_in = '0;
      active_in  = '0;
      src_idx    = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (j < int'(eff_len_in)) begin
            src_idx       = LEN_WIDTH'(int'(eff_len_in) - 1 - j);
            aligned_in[j] = pat_bytes[src_idx[LEN_WIDTH-2:0]];
            active_in[j]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
         eff_len_ff        <= '0;
         aligned_ff        <= '0;
         active_ff         <= '0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         pattern_length_ff <= pattern_length_in;
         eff_len_ff        <= eff_len_in;
         aligned_ff        <= aligned_in;
         active_ff         <= active_in;
      end
   end

   assign eff_len     = eff_len_ff;
   assign pat_aligned = aligned_ff;
   assign pat_active  = active_ff;

endmodule

### design/sstr_cell.sv
// One window cell: holds one recent text byte, passes it to its neighbor and
// compares its incoming byte against its aligned pattern byte. Depends on sstr_pkg.
`timescale 1ns / 1ps

module sstr_cell import sstr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  win_ctl_type           ctl,
   input  logic [BYTE_WIDTH-1:0] byte_in,
   input  logic [BYTE_WIDTH-1:0] pat_byte,
   input  logic                  active,
   output logic [BYTE_WIDTH-1:0] byte_out,
   output logic                  match_ok
);

   logic [BYTE_WIDTH-1:0] byte_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         byte_ff <= '0;
      end else if (ctl.shift) begin
         byte_ff <= byte_in;
      end
   end

   // The incoming byte is this cell's content once the window shifts.
   assign match_ok = !active || (byte_in == pat_byte);
   assign byte_out = byte_ff;

endmodule

### design/substring_search.sv
// Streaming substring search top level: counters, result register and the cell row.
// Depends on sstr_pkg, sstr_cfg and sstr_cell.
`timescale 1ns / 1ps

// Text words enter one byte per cycle; a zero byte ends the text. A row of
// MAX_PATTERN cells holds the newest bytes and compares all of them with the
// pattern in the cycle a byte is accepted, so the result for that byte sits in
// the output register in the next cycle. Each text gives exactly one result:
// found at the last byte of the first match (first byte for an empty pattern),
// or not found at the terminator. The only stall comes from the single output
// register: req_ready drops while a result waits and rsp_ready is low. Pattern
// writes take effect from the next accepted byte, even right after the write.

module substring_search import sstr_pkg::*; #(
   parameter int MAX_PATTERN    = MAX_PATTERN_DEFAULT,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_WIDTH-1:0]      req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [MATCH_POS_WIDTH-1:0] rsp_match_position,
   output logic                       rsp_overflowed,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   logic [LEN_WIDTH-1:0]                   eff_len;
   logic [MAX_PATTERN-1:0][BYTE_WIDTH-1:0] pat_aligned;
   logic [MAX_PATTERN-1:0]                 pat_active;
   logic [MAX_PATTERN-1:0][BYTE_WIDTH-1:0] win_bytes;
   logic [MAX_PATTERN-1:0]                 match_ok;
   win_ctl_type                            ctl;

   logic [POSITION_WIDTH-1:0] bytes_seen_ff, bytes_seen_in;
   logic                      result_given_ff, result_given_in;
   logic                      count_saturated_ff, count_saturated_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [MATCH_POS_WIDTH-1:0] rsp_pos_ff, rsp_pos_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                      accept, is_term, empty_pat, count_en, at_max;
   logic                      sat_step, hit, emit;
   logic [POSITION_WIDTH-1:0] seen_step, len_ext, pos_calc;

   sstr_cfg #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_cfg (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .eff_len        (eff_len),
      .pat_aligned    (pat_aligned),
      .pat_active     (pat_active)
   );

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [BYTE_WIDTH-1:0] cell_in;
      if (j == 0) begin : g_head
         assign cell_in = req_text_byte;
      end else begin : g_link
         assign cell_in = win_bytes[j-1];
      end
      sstr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .byte_in  (cell_in),
         .pat_byte (pat_aligned[j]),
         .active   (pat_active[j]),
         .byte_out (win_bytes[j]),
         .match_ok (match_ok[j])
      );
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_term   = (req_text_byte == '0);
   assign empty_pat = (eff_len == '0);

   always_comb begin
      ctl.clear = accept && is_term;
      ctl.shift = accept && !is_term && !result_given_ff && !empty_pat;
      // An empty pattern reports on the first byte without counting it.
      count_en  = accept && !is_term && !(empty_pat && !result_given_ff);
      at_max    = (bytes_seen_ff == POS_MAX);
      sat_step  = count_en ? (count_saturated_ff || at_max) : count_saturated_ff;
      seen_step = (count_en && !at_max) ? bytes_seen_ff + POSITION_WIDTH'(1)
                                        : bytes_seen_ff;
      hit       = ctl.shift && (&match_ok);
      emit      = accept && !result_given_ff && (empty_pat || is_term || hit);
      len_ext   = POSITION_WIDTH'(eff_len);
      pos_calc  = (sat_step || (seen_step < len_ext)) ? POS_MAX : seen_step - len_ext;

      bytes_seen_in      = ctl.clear ? '0 : seen_step;
      count_saturated_in = ctl.clear ? 1'b0 : sat_step;
      result_given_in    = ctl.clear ? 1'b0 : (result_given_ff || emit);

      rsp_found_in = empty_pat || !is_term;
      rsp_pos_in   = (empty_pat || is_term) ? '0 : MATCH_POS_WIDTH'(pos_calc);
      rsp_ovf_in   = sat_step;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff      <= '0;
         result_given_ff    <= 1'b0;
         count_saturated_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         bytes_seen_ff      <= bytes_seen_in;
         result_given_ff    <= result_given_in;
         count_saturated_ff <= count_saturated_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff <= rsp_found_in;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

   // A terminator leaves the per-text state and the whole window cleared.
   assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (bytes_seen_ff == '0) && !result_given_ff && !count_saturated_ff &&
                    (win_bytes == '0))
      else $error("per-text state not cleared after terminator");

   assert property (@(posedge clock) disable iff (reset)
      $rose(count_saturated_ff) |-> ($past(bytes_seen_ff) == POS_MAX))
      else $error("saturation flag set before the counter reached its maximum");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_position == '0))
      else $error("not-found result carries a nonzero position");

   // After a result the text is marked done, unless that byte ended the text.
   assert property (@(posedge clock) disable iff (reset)
      emit |=> (result_given_ff || $past(ctl.clear)))
      else $error("text not marked done after its result");

endmodule

### tb/search_result_checker.sv
// Scoreboard for the substring search block: tracks pattern writes and accepted text words,
// predicts each search result, and compares the results the block hands out.
// Depends on sstr_pkg.
`timescale 1ns / 1ps

module search_result_checker import sstr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [BYTE_WIDTH-1:0]      req_text_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_found,
   input  logic [MATCH_POS_WIDTH-1:0] rsp_match_position,
   input  logic                       rsp_overflowed,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                         mismatches,
   output int                         outstanding
);

   localparam int WINDOW     = MAX_PATTERN_DEFAULT;
   localparam int COUNT_BITS = POSITION_WIDTH_DEFAULT;
   localparam int REG_LANES  = CSR_DATA_WIDTH / BYTE_WIDTH;

   typedef struct packed {
      logic                       found;
      logic [MATCH_POS_WIDTH-1:0] position;
      logic                       overflowed;
   } search_result_type;

   logic [CSR_DATA_WIDTH-1:0] pattern_lo;
   logic [CSR_DATA_WIDTH-1:0] pattern_hi;
   logic [LEN_WIDTH-1:0]      pattern_len;

   logic [BYTE_WIDTH-1:0] window_bytes [WINDOW];
   logic [COUNT_BITS-1:0] text_count;
   logic                  reported;
   logic                  saturated;

   search_result_type pending_results [$];

   function automatic logic [BYTE_WIDTH-1:0] pattern_byte(input int idx);
      if (idx < REG_LANES) begin
         return pattern_lo[BYTE_WIDTH*idx +: BYTE_WIDTH];
      end
      return pattern_hi[BYTE_WIDTH*(idx-REG_LANES) +: BYTE_WIDTH];
   endfunction

   // The length register is clipped to the window and to the bytes the two
   // registers hold, and a zero byte cuts the pattern short like a C string.
   function automatic int active_length();
      int n;
      int i;
      n = int'(pattern_len);
      if (n > WINDOW) n = WINDOW;
      if (n > REG_BYTES) n = REG_BYTES;
      for (i = 0; i < n; i++) begin
         if (pattern_byte(i) == '0) return i;
      end
      return n;
   endfunction

   function automatic void clear_text();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      text_count = '0;
      reported   = 1'b0;
      saturated  = 1'b0;
   endfunction

   function automatic void search_byte(input logic [BYTE_WIDTH-1:0] b);
      search_result_type r;
      int                len;
      bit                hit;
      int                i;
      len = active_length();
      r.found      = 1'b0;
      r.position   = '0;
      r.overflowed = saturated;
      if (!reported && len == 0) begin
         // An empty pattern matches at once, even on the terminator.
         r.found = 1'b1;
         pending_results.push_back(r);
         if (b == '0) clear_text();
         else reported = 1'b1;
      end else if (b == '0) begin
         if (!reported) pending_results.push_back(r);
         clear_text();
      end else begin
         if (text_count == '1) saturated = 1'b1;
         else text_count = text_count + 1'b1;
         if (!reported) begin
            for (i = WINDOW - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
            window_bytes[0] = b;
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
               if (window_bytes[len-1-i] != pattern_byte(i)) hit = 1'b0;
            end
            if (hit) begin
               reported     = 1'b1;
               r.found      = 1'b1;
               r.overflowed = saturated;
               if (saturated || text_count < len) r.position = '1;
               else r.position = MATCH_POS_WIDTH'(int'(text_count) - len);
               pending_results.push_back(r);
            end
         end
      end
   endfunction

   always @(posedge clock) begin : monitor
      search_result_type want;
      if (reset) begin
         pattern_lo  = '0;
         pattern_hi  = '0;
         pattern_len = '0;
         clear_text();
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected: found %0b position %0d overflowed %0b",
                        $time, rsp_found, rsp_match_position, rsp_overflowed);
            end else begin
               want = pending_results.pop_front();
               if (rsp_found !== want.found) begin
                  mismatches++;
                  $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
               end
               if (rsp_match_position !== want.position) begin
                  mismatches++;
                  $display("%0t: match_position expected %0d actual %0d",
                           $time, want.position, rsp_match_position);
               end
               if (rsp_overflowed !== want.overflowed) begin
                  mismatches++;
                  $display("%0t: overflowed expected %0b actual %0b",
                           $time, want.overflowed, rsp_overflowed);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               REG_PATTERN_LOW:    pattern_lo  = csr_write_data;
               REG_PATTERN_HIGH:   pattern_hi  = csr_write_data;
               REG_PATTERN_LENGTH: pattern_len = csr_write_data[LEN_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) search_byte(req_text_byte);
      end
      outstanding = pending_results.size();
   end

endmodule

### tb/tb.sv
// Top of the substring search testbench: clock, reset, text and pattern stimulus, verdict.
// Depends on sstr_pkg, substring_search and search_result_checker.
`timescale 1ns / 1ps

module tb;
   import sstr_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
   localparam logic [BYTE_WIDTH-1:0]      TEXT_END   = 8'h00;
   localparam int GAP_PERCENT  = 23;
   localparam int RANDOM_BYTES = 900;
   localparam int REG_LANES    = CSR_DATA_WIDTH / BYTE_WIDTH;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_text_byte  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic                       rsp_found;
   logic [MATCH_POS_WIDTH-1:0] rsp_match_position;
   logic                       rsp_overflowed;
   logic                       csr_write_en   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = REG_PATTERN_LOW;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   int mismatches;
   int outstanding;
   bit no_gaps = 1'b0;

   substring_search dut (.*);
   search_result_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Offers one text word, with random gaps in front, and returns at the
   // falling edge after the word was taken.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
      while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic program_pattern(input logic [CSR_DATA_WIDTH-1:0] lo,
                                  input logic [CSR_DATA_WIDTH-1:0] hi,
                                  input logic [LEN_WIDTH-1:0] len);
      logic [CSR_DATA_WIDTH-1:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[LEN_WIDTH-1:0] = len;
      write_reg(REG_UNUSED, {$urandom, $urandom});
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LENGTH, len_word);
      csr_write_en <= 1'b0;
   endtask

   // Result side: random stalls, one long hold-off that backs the block up,
   // and a stretch where every result is taken at once.
   initial begin
      int taken;
      int hold_left;
      bit held;
      taken     = 0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) taken++;
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (taken == 60 && !held) begin
            held      = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (taken >= 90 && taken < 130) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= GAP_PERCENT);
         end
      end
   end

   initial begin
      logic [BYTE_WIDTH-1:0]     pat [REG_BYTES];
      logic [BYTE_WIDTH-1:0]     text_q [$];
      logic [CSR_DATA_WIDTH-1:0] lo;
      logic [CSR_DATA_WIDTH-1:0] hi;
      logic [LEN_WIDTH-1:0]      plen;
      int  sent;
      int  pick;
      int  used;
      int  tlen;
      int  at;
      int  k;
      bit  narrow;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers are zero after reset, so the pattern is empty.
      send_byte(TEXT_END);
      send_byte(8'hFF);
      send_byte(TEXT_END);

      // A zero byte inside the pattern cuts it to three bytes even though the
      // length register holds its largest value.
      drain_results();
      program_pattern(64'hAABBCCDD_00030201, '1, '1);
      send_byte(8'h01);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      send_byte(8'h7F);
      send_byte(TEXT_END);
      send_byte(8'hFE);
      send_byte(TEXT_END);

      // Pattern changed in the middle of a text: the earlier word stays in
      // the window and still counts toward the match position.
      drain_results();
      program_pattern(64'h7978, '0, 5'd2);
      send_byte("x");
      drain_results();
      program_pattern(64'h7A79, '0, 5'd2);
      send_byte("y");
      send_byte("z");
      send_byte(TEXT_END);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         drain_results();
         // Words go out without gaps for a stretch in the middle of the run.
         no_gaps = (sent >= 300 && sent < 500);
         narrow = ($urandom_range(99) < 70);
         for (k = 0; k < REG_BYTES; k++) begin
            if (narrow) pat[k] = BYTE_WIDTH'("a" + $urandom_range(2));
            else pat[k] = BYTE_WIDTH'($urandom_range(255));
         end
         for (k = 0; k < REG_LANES; k++) begin
            lo[BYTE_WIDTH*k +: BYTE_WIDTH] = pat[k];
            hi[BYTE_WIDTH*k +: BYTE_WIDTH] = pat[k+REG_LANES];
         end
         pick = $urandom_range(99);
         if (pick < 10) plen = '0;
         else if (pick < 70) plen = LEN_WIDTH'($urandom_range(1, 4));
         else if (pick < 90) plen = LEN_WIDTH'($urandom_range(5, REG_BYTES));
         else plen = LEN_WIDTH'($urandom_range(REG_BYTES + 1, (1 << LEN_WIDTH) - 1));
         program_pattern(lo, hi, plen);

         used = (int'(plen) > REG_BYTES) ? REG_BYTES : int'(plen);
         for (k = 0; k < used; k++) begin
            if (pat[k] == TEXT_END) used = k;
         end

         repeat ($urandom_range(3, 8)) begin
            text_q.delete();
            tlen = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
            for (k = 0; k < tlen; k++) begin
               if (narrow && $urandom_range(9) != 0) begin
                  text_q.push_back(BYTE_WIDTH'("a" + $urandom_range(2)));
               end else begin
                  text_q.push_back(BYTE_WIDTH'($urandom_range(1, 255)));
               end
            end
            if ($urandom_range(99) < 60) begin
               at = $urandom_range(text_q.size());
               for (k = used - 1; k >= 0; k--) text_q.insert(at, pat[k]);
            end
            foreach (text_q[k]) send_byte(text_q[k]);
            send_byte(TEXT_END);
            sent += text_q.size() + 1;
         end
      end
      no_gaps = 1'b0;

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
